### rtl/wavetable_lfo_interp_core_defines.svh
// assertion macros for the wavetable lfo core
`ifndef WAVETABLE_LFO_INTERP_CORE_DEFINES_SVH
`define WAVETABLE_LFO_INTERP_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define WLFO_ASSERT_NOW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define WLFO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define WLFO_ASSERT_NOW(lbl, prop, msg)
`define WLFO_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/wlfo_pkg.sv
// shared types and constants of the wavetable lfo core
package wlfo_pkg;

  localparam int TableSize  = 512;
  localparam int AddrW      = $clog2(TableSize);
  localparam int FracW      = 16;
  localparam int HeadW      = AddrW + FracW;
  localparam int SampleW    = 16;
  localparam int IncW       = 25;
  localparam int GainW      = 16;
  localparam int GainFracW  = 12;
  localparam int OutW       = 20;
  localparam int OutShift   = FracW + GainFracW + SampleW - 16;
  localparam int ProdW      = SampleW + FracW + 2;
  localparam int ScaledW    = ProdW + GainW + 1;
  localparam int ShiftedW   = ScaledW - OutShift;
  localparam int CmdW       = HeadW;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCountW    = $clog2(QueueDepth + 1);
  localparam int PaddrW     = 3;
  localparam int PdataW     = 32;

  localparam logic [GainW-1:0] GainReset = GainW'(4096);

  localparam logic RegIdxIncrement = 1'b0;
  localparam logic RegIdxGain      = 1'b1;

  typedef enum logic [1:0] {
    ACT_TICK        = 2'd0,
    ACT_WRITE       = 2'd1,
    ACT_PHASE_RESET = 2'd2,
    ACT_SET_OFFSET  = 2'd3
  } action_e;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [CmdW-1:0]   payload;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_B,
    ST_MIX,
    ST_SCALE,
    ST_OUT
  } back_state_e;

endpackage

### rtl/wlfo_if.sv
// valid/ready channel interfaces for input items and result items
interface wlfo_in_if import wlfo_pkg::*; ();
  logic                valid;
  logic                ready;
  action_e             action;
  logic [AddrW-1:0]    table_address;
  logic signed [15:0]  table_data;
  logic [AddrW-1:0]    phase_value;

  modport source (output valid, action, table_address, table_data, phase_value, input ready);
  modport sink (input valid, action, table_address, table_data, phase_value, output ready);
endinterface

interface wlfo_out_if import wlfo_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OutW-1:0]  sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface

### rtl/wlfo_ram.sv
// generic single-port ram with registered read
module wlfo_ram #(
  parameter int Width = 16,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/wlfo_front.sv
// front end: takes input beats, keeps play head and phase offset, queues commands
module wlfo_front import wlfo_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  wlfo_in_if.sink         in_i,
  input  logic [IncW-1:0] inc_i,
  input  logic            q_full_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  logic [HeadW-1:0] head_q, head_d;
  logic [AddrW-1:0] offset_q, offset_d;
  logic             accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;

  always_comb begin
    head_d        = head_q;
    offset_d      = offset_q;
    push_o        = 1'b0;
    cmd_o.kind    = CMD_WRITE;
    cmd_o.payload = {in_i.table_address, in_i.table_data};
    if (accept) begin
      unique case (in_i.action)
        ACT_TICK: begin
          head_d        = head_q + inc_i;
          push_o        = 1'b1;
          cmd_o.kind    = CMD_TICK;
          cmd_o.payload = head_d;
        end
        ACT_WRITE: begin
          push_o = 1'b1;
        end
        ACT_PHASE_RESET: begin
          head_d = {offset_q, {FracW{1'b0}}};
        end
        ACT_SET_OFFSET: begin
          head_d   = head_q + {in_i.phase_value, {FracW{1'b0}}}
                     - {offset_q, {FracW{1'b0}}};
          offset_d = in_i.phase_value;
        end
        default: begin
          head_d = head_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      offset_q <= '0;
    end else begin
      head_q   <= head_d;
      offset_q <= offset_d;
    end
  end

endmodule

### rtl/wlfo_queue.sv
// short command queue between front and back
module wlfo_queue import wlfo_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cmd_t          cmd_i,
  input  logic          pop_i,
  output cmd_t          cmd_o,
  output queue_status_t status_o
);

  cmd_t               slot_q [QueueDepth];
  logic [QPtrW-1:0]   wptr_q, rptr_q;
  logic [QCountW-1:0] count_q;

  assign status_o.full  = (count_q == QCountW'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign cmd_o          = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### rtl/wlfo_back.sv
// back end: table writes, two table reads, interpolation, gain and rounding
module wlfo_back import wlfo_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  cmd_t             cmd_i,
  output logic             pop_o,
  input  logic [GainW-1:0] gain_i,
  wlfo_out_if.source       res_o,
  output logic             busy_o
);

  back_state_e state_q, state_d;

  logic                       ram_en, ram_we;
  logic [AddrW-1:0]           ram_addr;
  logic [SampleW-1:0]         ram_wdata, ram_rdata;

  logic [AddrW-1:0]           idx_q;
  logic [FracW-1:0]           frac_q;
  logic signed [SampleW-1:0]  a_q;
  logic signed [ProdW-1:0]    prod_q;
  logic signed [ScaledW-1:0]  scaled_q;
  logic                       out_valid_q;
  logic signed [OutW-1:0]     out_q;

  logic                       load_pos, load_a, load_prod, load_scaled, load_out;
  logic signed [SampleW:0]    diff;
  logic signed [ProdW-1:0]    mix;
  logic signed [ScaledW-1:0]  rounded;
  logic signed [ShiftedW-1:0] shifted;
  logic                       in_range;
  logic signed [OutW-1:0]     result;

  wlfo_ram #(
    .Width (SampleW),
    .Depth (TableSize)
  ) u_table (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign diff = $signed({ram_rdata[SampleW-1], ram_rdata}) - $signed({a_q[SampleW-1], a_q});
  assign mix  = $signed({{2{a_q[SampleW-1]}}, a_q, {FracW{1'b0}}}) + prod_q;

  assign rounded  = scaled_q + (ScaledW'(1) <<< (OutShift - 1));
  assign shifted  = $signed(rounded[ScaledW-1:OutShift]);
  assign in_range = (&shifted[ShiftedW-1:OutW-1]) || !(|shifted[ShiftedW-1:OutW-1]);
  assign result   = in_range ? shifted[OutW-1:0]
                  : (shifted[ShiftedW-1] ? {1'b1, {(OutW-1){1'b0}}}
                                         : {1'b0, {(OutW-1){1'b1}}});

  assign busy_o          = (state_q != ST_IDLE);
  assign res_o.valid     = out_valid_q;
  assign res_o.sample_out = out_q;

  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = idx_q;
    ram_wdata   = cmd_i.payload[SampleW-1:0];
    load_pos    = 1'b0;
    load_a      = 1'b0;
    load_prod   = 1'b0;
    load_scaled = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o    = 1'b1;
          ram_en   = 1'b1;
          ram_addr = cmd_i.payload[CmdW-1 -: AddrW];
          if (cmd_i.kind == CMD_WRITE) begin
            ram_we = 1'b1;
          end else begin
            load_pos = 1'b1;
            state_d  = ST_READ_B;
          end
        end
      end
      ST_READ_B: begin
        ram_en   = 1'b1;
        ram_addr = idx_q + 1'b1;
        load_a   = 1'b1;
        state_d  = ST_MIX;
      end
      ST_MIX: begin
        load_prod = 1'b1;
        state_d   = ST_SCALE;
      end
      ST_SCALE: begin
        load_scaled = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || res_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_pos) begin
      idx_q  <= cmd_i.payload[CmdW-1 -: AddrW];
      frac_q <= cmd_i.payload[FracW-1:0];
    end
    if (load_a) begin
      a_q <= $signed(ram_rdata);
    end
    if (load_prod) begin
      prod_q <= diff * $signed({1'b0, frac_q});
    end
    if (load_scaled) begin
      scaled_q <= mix * $signed({1'b0, gain_i});
    end
    if (load_out) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### rtl/wavetable_lfo_interp_core.sv
// top level of the wavetable lfo core with linear interpolation
// Wavetable LFO: a tick beat advances a Q9.16 play head by phase_increment, reads the two
// neighboring samples of a 512-entry table and returns their linear interpolation times a
// Q4.12 gain as a Q5.15 sample, rounded half up and saturated to 20 bits. The front end takes
// one input beat per cycle while its two-entry command queue has room; head and offset
// actions finish in the front end at once. The back end owns the single-port table RAM: a
// table write is done from the idle state, and a tick steps through two reads on the one RAM
// port, the difference multiply, the gain multiply and rounding into the output register,
// which waits while an unaccepted result still holds it; no new command is taken until the
// tick is through. The table has no reset and no clearing pass; read only written entries.
// Registers sit at byte addresses 0 (phase_increment) and 4 (output_gain).
`include "wavetable_lfo_interp_core_defines.svh"

module wavetable_lfo_interp_core import wlfo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  wlfo_in_if.sink           in_i,
  wlfo_out_if.source        res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  logic [IncW-1:0]  inc_q, inc_d;
  logic [GainW-1:0] gain_q, gain_d;
  logic             reg_idx;
  logic             cfg_write;

  logic          push, pop, back_busy;
  cmd_t          cmd_in, cmd_out;
  queue_status_t q_status;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[2];
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    inc_d  = inc_q;
    gain_d = gain_q;
    prdata = '0;
    unique case (reg_idx)
      RegIdxIncrement: begin
        prdata = PdataW'(inc_q);
        if (cfg_write) begin
          inc_d = pwdata[IncW-1:0];
        end
      end
      RegIdxGain: begin
        prdata = PdataW'(gain_q);
        if (cfg_write) begin
          gain_d = pwdata[GainW-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q  <= '0;
      gain_q <= GainReset;
    end else begin
      inc_q  <= inc_d;
      gain_q <= gain_d;
    end
  end

  wlfo_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .inc_i    (inc_q),
    .q_full_i (q_status.full),
    .push_o   (push),
    .cmd_o    (cmd_in)
  );

  wlfo_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd_in),
    .pop_i    (pop),
    .cmd_o    (cmd_out),
    .status_o (q_status)
  );

  wlfo_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_status.empty),
    .cmd_i     (cmd_out),
    .pop_o     (pop),
    .gain_i    (gain_q),
    .res_o     (res_o),
    .busy_o    (back_busy)
  );

  `WLFO_ASSERT_NOW(a_queue_consistent, !(q_status.full && q_status.empty), "queue full and empty")
  `WLFO_ASSERT_NEXT(a_push_lands, push && !pop, !q_status.empty, "queued command lost")
  `WLFO_ASSERT_NOW(a_result_from_back, $rose(res_o.valid) |-> $past(back_busy), "result not from back")

endmodule

### tb/sv/tb_top.sv
// testbench for the wavetable lfo core: predicts every tick result and checks it against the block
`timescale 1ns / 1ps

module tb_top import wlfo_pkg::*; ();

  localparam int CycleLimit = 500000;
  localparam int DrainCycles = 20;
  localparam int HoldCycles = 400;
  localparam int PhaseItems = 45;

  class lfo_scoreboard;
    logic [HeadW-1:0]          head;
    logic [AddrW-1:0]          offset;
    logic [IncW-1:0]           inc;
    logic [GainW-1:0]          gain;
    logic signed [SampleW-1:0] wave [TableSize];
    bit                        written [TableSize];
    logic signed [OutW-1:0]    pending [$];
    int                        errors;

    function new();
      head = '0;
      offset = '0;
      inc = '0;
      gain = GainReset;
      errors = 0;
      foreach (written[i]) begin
        written[i] = 1'b0;
        wave[i] = '0;
      end
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function logic signed [OutW-1:0] interp_sample();
      logic [AddrW-1:0] i0;
      logic [AddrW-1:0] i1;
      longint a;
      longint b;
      longint f;
      longint mix;
      longint prod;
      longint r;
      i0 = head[HeadW-1:FracW];
      i1 = i0 + 1'b1;
      a = wave[i0];
      b = wave[i1];
      f = longint'(head[FracW-1:0]);
      mix = a * ((longint'(1) <<< FracW) - f) + b * f;
      prod = mix * longint'(gain);
      r = (prod + (longint'(1) <<< (OutShift - 1))) >>> OutShift;
      if (r > (longint'(1) <<< (OutW - 1)) - 1) r = (longint'(1) <<< (OutW - 1)) - 1;
      if (r < -(longint'(1) <<< (OutW - 1))) r = -(longint'(1) <<< (OutW - 1));
      return r[OutW-1:0];
    endfunction

    function void note_input(action_e act, logic [AddrW-1:0] addr,
                             logic signed [15:0] data, logic [AddrW-1:0] pval);
      case (act)
        ACT_TICK: begin
          head = head + HeadW'(inc);
          pending.push_back(interp_sample());
        end
        ACT_WRITE: begin
          wave[addr] = data;
          written[addr] = 1'b1;
        end
        ACT_PHASE_RESET: begin
          head = {offset, {FracW{1'b0}}};
        end
        default: begin
          head = head + {pval, {FracW{1'b0}}} - {offset, {FracW{1'b0}}};
          offset = pval;
        end
      endcase
    endfunction

    task check_sample(logic signed [OutW-1:0] got);
      logic signed [OutW-1:0] want;
      if (pending.size() == 0) begin
        report($sformatf("sample_out %0d with no tick waiting", got));
      end else begin
        want = pending.pop_front();
        if (got !== want) report($sformatf("sample_out %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  wlfo_in_if  in_if ();
  wlfo_out_if res_if ();

  wavetable_lfo_interp_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lfo_scoreboard sb;
  int src_idle_pct;
  int snk_idle_pct;
  bit hold_req;
  int cycle_count;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("wavetable_lfo_interp_core verification failed");
      $finish;
    end
  end

  // result side: random ready, with one long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        res_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      res_if.ready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) sb.check_sample(res_if.sample_out);
  end

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_item(action_e act, logic [AddrW-1:0] addr,
                           logic signed [15:0] data, logic [AddrW-1:0] pval);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.action = act;
    in_if.table_address = addr;
    in_if.table_data = data;
    in_if.phase_value = pval;
    in_if.valid = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(act, addr, data, pval);
  endtask

  task automatic write_entry(logic [AddrW-1:0] addr, logic signed [15:0] data);
    send_item(ACT_WRITE, addr, data, AddrW'($urandom()));
  endtask

  task automatic send_phase_reset();
    send_item(ACT_PHASE_RESET, AddrW'($urandom()), 16'($urandom()), AddrW'($urandom()));
  endtask

  task automatic send_offset(logic [AddrW-1:0] pval);
    send_item(ACT_SET_OFFSET, AddrW'($urandom()), 16'($urandom()), pval);
  endtask

  // loads any unwritten entry the next tick would read before sending the tick
  task automatic send_tick();
    logic [HeadW-1:0] next_head;
    logic [AddrW-1:0] idx;
    next_head = sb.head + HeadW'(sb.inc);
    for (int k = 0; k < 2; k++) begin
      idx = next_head[HeadW-1:FracW] + AddrW'(k);
      if (!sb.written[idx]) write_entry(idx, rand_sample());
    end
    send_item(ACT_TICK, AddrW'($urandom()), 16'($urandom()), AddrW'($urandom()));
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) send_tick();
    else if (pick < 80) write_entry(AddrW'($urandom()), rand_sample());
    else if (pick < 88) send_phase_reset();
    else send_offset(AddrW'($urandom()));
  endtask

  task automatic write_reg(logic idx, logic [PdataW-1:0] value);
    logic [PdataW-1:0] want;
    logic [PdataW-1:0] got;
    want = (idx == RegIdxIncrement) ? PdataW'(value[IncW-1:0]) : PdataW'(value[GainW-1:0]);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = PaddrW'(4 * idx);
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == RegIdxIncrement) sb.inc = value[IncW-1:0];
    else sb.gain = value[GainW-1:0];
    @(negedge clk_i);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    if (got !== want) sb.report($sformatf("register %0d reads %0h, expected %0h", idx, got, want));
  endtask

  task automatic drain_block();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    cycle_count = 0;
    hold_req = 1'b0;
    src_idle_pct = 7;
    snk_idle_pct = 64;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.action = ACT_TICK;
    in_if.table_address = '0;
    in_if.table_data = '0;
    in_if.phase_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(RegIdxIncrement, 32'h0001_8000);
    write_reg(RegIdxGain, 32'd4096);

    // directed: sample extremes, both wrap points of the table, offset moves
    write_entry(9'd0, 16'sh7fff);
    write_entry(9'd1, -16'sh8000);
    write_entry(9'd2, 16'sh0000);
    write_entry(9'd511, -16'sh0001);
    write_entry(9'd510, 16'sh7fff);
    send_tick();
    send_tick();
    send_offset(9'd510);
    send_phase_reset();
    send_tick();
    send_tick();
    send_offset(9'd0);
    send_tick();
    send_phase_reset();
    send_tick();
    write_entry(9'd0, -16'sh8000);
    write_entry(9'd1, -16'sh8000);
    send_offset(9'd511);
    send_phase_reset();
    send_tick();
    write_entry(9'd0, 16'sh7fff);
    write_entry(9'd1, 16'sh7fff);
    send_phase_reset();
    send_tick();
    drain_block();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin src_idle_pct = 7;  snk_idle_pct = 64; end
        1: begin src_idle_pct = 64; snk_idle_pct = 7;  end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      case (ph)
        0: begin
          write_reg(RegIdxIncrement, 32'h0000_0000);
          write_reg(RegIdxGain, 32'h0000_ffff);
        end
        1: begin
          write_reg(RegIdxIncrement, 32'h01ff_ffff);
          write_reg(RegIdxGain, 32'h0000_0000);
        end
        2: begin
          write_reg(RegIdxIncrement, 32'h0000_0001);
          write_reg(RegIdxGain, 32'd4096);
        end
        3: begin
          write_reg(RegIdxIncrement, 32'h0001_0000);
          write_reg(RegIdxGain, 32'h0000_8000);
        end
        default: begin
          write_reg(RegIdxIncrement, $urandom());
          write_reg(RegIdxGain, $urandom());
        end
      endcase
      if (ph == 0) hold_req = 1'b1;
      repeat (PhaseItems) random_item();
      drain_block();
    end

    if (sb.errors == 0) begin
      $display("wavetable_lfo_interp_core verification clean");
    end else begin
      $display("wavetable_lfo_interp_core verification failed");
    end
    $finish;
  end

endmodule
